// ===== rtl/tsc_pkg.sv =====
// Package: widths, constants, state types and saturation for the Taylor sine/cosine core.
`timescale 1ns / 1ps

package tsc_pkg;

   localparam int ANGLE_W    = 32;
   localparam int Q130_W     = 32;
   localparam int TERMS_W    = 6;
   localparam int THR_W      = 21;
   localparam int AX_W       = 31;
   localparam int X2_W       = 34;
   localparam int MAG_W      = 36;
   localparam int HALF_W     = MAG_W / 2;
   localparam int PROD_W     = MAG_W + X2_W;
   localparam int FRAC_SHIFT = 29;
   localparam int ACC_W      = 40;
   localparam int DIV_CNT_W  = $clog2(MAG_W + 1);

   localparam logic [THR_W-1:0]          THR_RESET = 21'd107;
   localparam logic signed [ANGLE_W-1:0] PI_Q229   = 32'sd1686629713;
   localparam logic [MAG_W-1:0]          ONE_MAG   = 36'd1073741824;
   localparam logic signed [ACC_W-1:0]   ONE_ACC   = 40'sd1073741824;
   localparam logic signed [Q130_W-1:0]  ONE_Q130  = 32'sd1073741824;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_START,
      ST_SQ_WAIT,
      ST_INIT,
      ST_MUL_START,
      ST_MUL_WAIT,
      ST_DIV_WAIT,
      ST_DONE
   } tsc_state_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_LOW,
      MUL_HIGH,
      MUL_SUM
   } tsc_mul_state_type;

   function automatic logic signed [Q130_W-1:0] saturate_q130(
      input logic signed [ACC_W-1:0] v
   );
      logic signed [Q130_W-1:0] r;
      if (v > ONE_ACC) begin
         r = ONE_Q130;
      end else if (v < -ONE_ACC) begin
         r = -ONE_Q130;
      end else begin
         r = v[Q130_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/tsc_if.sv =====
// Interfaces: angle request channel and sine/cosine response channel.
`timescale 1ns / 1ps

interface tsc_req_if;
   import tsc_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [ANGLE_W-1:0]  angle;

   modport source (output valid, output angle, input ready);
   modport sink (input valid, input angle, output ready);
endinterface

interface tsc_rsp_if;
   import tsc_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [Q130_W-1:0]   sine;
   logic signed [Q130_W-1:0]   cosine;
   logic [TERMS_W-1:0]         terms_used;

   modport source (output valid, output sine, output cosine, output terms_used, input ready);
   modport sink (input valid, input sine, input cosine, input terms_used, output ready);
endinterface

// ===== rtl/taylor_sine_cosine_core.sv =====
// Top level: Taylor-series sine and cosine of one angle, one item at a time.
// Each series term costs a shared multiply and a bit-serial divide.
// Throughput: one item in flight; the next transfer is taken once the result is registered.
// Reset: synchronous, active high; clears the sequencer and output valid, threshold to 107.
`timescale 1ns / 1ps

module taylor_sine_cosine_core #(
   parameter int MAX_TERMS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [tsc_pkg::THR_W-1:0]   csr_wr_data,
   tsc_req_if.sink                     req_if,
   tsc_rsp_if.source                   rsp_if
);
   import tsc_pkg::*;

   // term counter, series index n and denominator (n+1)(n+2) widths
   localparam int CNT_W = $clog2(MAX_TERMS + 1);
   localparam int N_W   = $clog2(2 * MAX_TERMS + 2);
   localparam int DEN_W = $clog2((2 * MAX_TERMS) * (2 * MAX_TERMS + 1) + 1);
   localparam int DPR_W = 2 * (N_W + 1);

   tsc_state_type              state_ff, state_in;
   logic [THR_W-1:0]           thr_ff;
   logic                       cos_phase_ff;

   // angle and series datapath
   logic [AX_W-1:0]            ax_ff;
   logic                       neg_ff;
   logic [X2_W-1:0]            x2_ff;
   logic [MAG_W-1:0]           mag_ff;
   logic                       term_neg_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [ACC_W-1:0]    sine_sum_ff;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           sine_cnt_ff;
   logic [N_W-1:0]             n_ff;

   // response register
   logic                       rsp_valid_ff;
   logic signed [Q130_W-1:0]   rsp_sine_ff;
   logic signed [Q130_W-1:0]   rsp_cosine_ff;
   logic [TERMS_W-1:0]         rsp_terms_ff;

   // shared units
   logic                       mul_start;
   logic [MAG_W-1:0]           mul_a;
   logic [X2_W-1:0]            mul_b;
   logic                       mul_done;
   logic [PROD_W-1:0]          mul_product;
   logic                       div_start;
   logic [DEN_W-1:0]           den;
   logic [DPR_W-1:0]           den_full;
   logic                       div_done;
   logic [MAG_W-1:0]           div_quotient;

   // misc combinational terms
   logic signed [ANGLE_W-1:0]  angle_sat;
   logic [ANGLE_W-1:0]         angle_abs;
   logic [MAG_W-1:0]           init_mag;
   logic signed [ACC_W-1:0]    init_ext;
   logic signed [ACC_W-1:0]    quo_ext;
   logic                       series_stop;
   logic                       out_free;
   logic                       req_ready;

   // clamp the angle to plus or minus pi and split into sign and magnitude
   always_comb begin
      if (req_if.angle > PI_Q229) begin
         angle_sat = PI_Q229;
      end else if (req_if.angle < -PI_Q229) begin
         angle_sat = -PI_Q229;
      end else begin
         angle_sat = req_if.angle;
      end
      angle_abs = angle_sat[ANGLE_W-1] ? ANGLE_W'(-angle_sat) : ANGLE_W'(angle_sat);
   end

   // first term: x in Q1.30 for sine, one for cosine
   assign init_mag = cos_phase_ff ? ONE_MAG : MAG_W'({ax_ff, 1'b0});
   assign init_ext = signed'(ACC_W'(init_mag));
   assign quo_ext  = signed'(ACC_W'(div_quotient));

   // denominator (n+1)(n+2) for the term now being formed
   assign den_full = (DPR_W'(n_ff) + DPR_W'(1)) * (DPR_W'(n_ff) + DPR_W'(2));
   assign den      = den_full[DEN_W-1:0];

   // accumulate with the flipped sign; stop on a small term or at the term limit
   assign acc_in      = term_neg_ff ? acc_ff + quo_ext : acc_ff - quo_ext;
   assign count_in    = count_ff + 1'b1;
   assign series_stop = (div_quotient <= MAG_W'(thr_ff)) || (count_in >= CNT_W'(MAX_TERMS));

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      mul_start = 1'b0;
      div_start = 1'b0;
      mul_a     = mag_ff;
      mul_b     = x2_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_if.valid) begin
               state_in = ST_SQ_START;
            end
         end
         ST_SQ_START: begin
            // square the magnitude on the shared multiplier
            mul_start = 1'b1;
            mul_a     = MAG_W'(ax_ff);
            mul_b     = X2_W'(ax_ff);
            state_in  = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (mul_done) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            state_in = ST_MUL_START;
         end
         ST_MUL_START: begin
            mul_start = 1'b1;
            state_in  = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            // hand the scaled term straight to the divider
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               if (!series_stop) begin
                  state_in = ST_MUL_START;
               end else if (!cos_phase_ff) begin
                  state_in = ST_INIT;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            // hold until the response slot is free
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // sequencer control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cos_phase_ff <= 1'b0;
         count_ff     <= '0;
         n_ff         <= '0;
      end else begin
         unique case (state_ff)
            ST_INIT: begin
               count_ff <= '0;
               n_ff     <= cos_phase_ff ? N_W'(0) : N_W'(1);
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  count_ff <= count_in;
                  n_ff     <= n_ff + N_W'(2);
                  if (series_stop) begin
                     cos_phase_ff <= 1'b1;
                  end
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  cos_phase_ff <= 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // series datapath
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_if.valid) begin
         ax_ff  <= angle_abs[AX_W-1:0];
         neg_ff <= angle_sat[ANGLE_W-1];
      end
      if (state_ff == ST_SQ_WAIT && mul_done) begin
         x2_ff <= mul_product[FRAC_SHIFT+X2_W-1:FRAC_SHIFT];
      end
      if (state_ff == ST_INIT) begin
         mag_ff      <= init_mag;
         term_neg_ff <= cos_phase_ff ? 1'b0 : neg_ff;
         acc_ff      <= (!cos_phase_ff && neg_ff) ? -init_ext : init_ext;
      end
      if (state_ff == ST_DIV_WAIT && div_done) begin
         mag_ff      <= div_quotient;
         term_neg_ff <= !term_neg_ff;
         acc_ff      <= acc_in;
         // keep the finished sine sum while the cosine series runs
         if (series_stop && !cos_phase_ff) begin
            sine_sum_ff <= acc_in;
            sine_cnt_ff <= count_in;
         end
      end
   end

   // response register: load on completion, drop valid after the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_sine_ff   <= saturate_q130(sine_sum_ff);
         rsp_cosine_ff <= saturate_q130(acc_ff);
         rsp_terms_ff  <= TERMS_W'(sine_cnt_ff);
      end
   end

   tsc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   tsc_div #(
      .DIVISOR_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_product[FRAC_SHIFT+MAG_W-1:FRAC_SHIFT]),
      .divisor  (den),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_if.ready      = req_ready;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.sine       = rsp_sine_ff;
   assign rsp_if.cosine     = rsp_cosine_ff;
   assign rsp_if.terms_used = rsp_terms_ff;

   // multiplier results arrive only while the sequencer waits for them
   assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_SQ_WAIT || state_ff == ST_MUL_WAIT))
      else $error("multiplier finished outside a wait state");

   // divider results arrive only while the sequencer waits for them
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider finished outside its wait state");

   // the term counter never passes the term limit
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TERMS))
      else $error("term count beyond limit");

   // a held result reports between one and MAX_TERMS sine terms
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_terms_ff != '0 && rsp_terms_ff <= TERMS_W'(MAX_TERMS)))
      else $error("reported term count out of range");

   // a new item enters only while no series is in progress
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_if.valid) |=> (state_ff == ST_SQ_START && !cos_phase_ff))
      else $error("item accepted with a series in progress");

endmodule

// ===== rtl/tsc_mul.sv =====
// Shared multiplier: full product of two operands over two half-width passes.
`timescale 1ns / 1ps

module tsc_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tsc_pkg::MAG_W-1:0]    mul_a,
   input  logic [tsc_pkg::X2_W-1:0]     mul_b,
   output logic                         done,
   output logic [tsc_pkg::PROD_W-1:0]   product
);
   import tsc_pkg::*;

   tsc_mul_state_type             state_ff, state_in;
   logic                          done_ff;
   logic [MAG_W-1:0]              a_ff;
   logic [X2_W-1:0]               b_ff;
   logic [HALF_W+X2_W-1:0]        part_ff, part_in;
   logic [PROD_W-1:0]             sum_ff;
   logic [HALF_W-1:0]             half_op;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MUL_IDLE: begin
            if (start) begin
               state_in = MUL_LOW;
            end
         end
         MUL_LOW:  state_in = MUL_HIGH;
         MUL_HIGH: state_in = MUL_SUM;
         MUL_SUM:  state_in = MUL_IDLE;
         default:  state_in = MUL_IDLE;
      endcase
   end

   // one multiplier, fed the low half first and the high half second
   assign half_op = (state_ff == MUL_LOW) ? a_ff[HALF_W-1:0] : a_ff[MAG_W-1:HALF_W];
   assign part_in = (HALF_W + X2_W)'(half_op) * (HALF_W + X2_W)'(b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MUL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == MUL_SUM);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == MUL_IDLE && start) begin
         a_ff <= mul_a;
         b_ff <= mul_b;
      end
      if (state_ff == MUL_LOW || state_ff == MUL_HIGH) begin
         part_ff <= part_in;
      end
      if (state_ff == MUL_HIGH) begin
         sum_ff <= PROD_W'(part_ff);
      end else if (state_ff == MUL_SUM) begin
         sum_ff <= sum_ff + {part_ff, {HALF_W{1'b0}}};
      end
   end

   assign done    = done_ff;
   assign product = sum_ff;

endmodule

// ===== rtl/tsc_div.sv =====
// Restoring divider: one quotient bit per cycle, truncating unsigned quotient.
`timescale 1ns / 1ps

module tsc_div #(
   parameter int DIVISOR_W = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tsc_pkg::MAG_W-1:0]   dividend,
   input  logic [DIVISOR_W-1:0]        divisor,
   output logic                        done,
   output logic [tsc_pkg::MAG_W-1:0]   quotient
);
   import tsc_pkg::*;

   logic                      busy_ff;
   logic                      done_ff;
   logic [DIV_CNT_W-1:0]      cnt_ff;
   logic [DIVISOR_W-1:0]      divisor_ff;
   logic [DIVISOR_W-1:0]      rem_ff, rem_in;
   logic [MAG_W-1:0]          quo_ff, quo_in;
   logic [DIVISOR_W:0]        shifted;
   logic [DIVISOR_W+1:0]      diff;
   logic                      fits;

   assign shifted = {rem_ff, quo_ff[MAG_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, divisor_ff};
   assign fits    = !diff[DIVISOR_W+1];
   assign rem_in  = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
   assign quo_in  = {quo_ff[MAG_W-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(MAG_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         quo_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
